/* rtl/tcws_pkg.sv */
// ----------------------------------------------------------------------------
// tcws_pkg
// Shared codes and field widths of the timed cue window scheduler.
// ----------------------------------------------------------------------------
package tcws_pkg;

  localparam int REQ_W   = 2;
  localparam int ACT_W   = 2;
  localparam int ID_W    = 16;
  localparam int DELAY_W = 33;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SHOW  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

endpackage

/* rtl/tcws_req_if.sv */
// ----------------------------------------------------------------------------
// tcws_req_if
// Request channel: push, tick or flush with cue and clock fields.
// ----------------------------------------------------------------------------
interface tcws_req_if #(
  parameter int TIME_BITS = 48
);
  import tcws_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [REQ_W-1:0]            req_type;
  logic signed [TIME_BITS-1:0] cue_start_us;
  logic signed [TIME_BITS-1:0] cue_end_us;
  logic                        cue_is_bitmap;
  logic [ID_W-1:0]             cue_payload_id;
  logic                        cue_renderable;
  logic signed [TIME_BITS-1:0] now_us;
  logic                        clock_valid;

  modport source (
    output valid, req_type, cue_start_us, cue_end_us, cue_is_bitmap, cue_payload_id,
           cue_renderable, now_us, clock_valid,
    input  ready
  );
  modport sink (
    input  valid, req_type, cue_start_us, cue_end_us, cue_is_bitmap, cue_payload_id,
           cue_renderable, now_us, clock_valid,
    output ready
  );
endinterface

/* rtl/tcws_res_if.sv */
// ----------------------------------------------------------------------------
// tcws_res_if
// Result channel: echoed shifted times, display action and store fill.
// ----------------------------------------------------------------------------
interface tcws_res_if #(
  parameter int TIME_BITS = 48,
  parameter int CNT_W     = 11
);
  import tcws_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [TIME_BITS-1:0] shifted_start_us;
  logic signed [TIME_BITS-1:0] shifted_end_us;
  logic [ACT_W-1:0]            display_action;
  logic [ID_W-1:0]             shown_payload_id;
  logic                        shown_is_bitmap;
  logic [CNT_W-1:0]            stored_count;

  modport source (
    output valid, shifted_start_us, shifted_end_us, display_action, shown_payload_id,
           shown_is_bitmap, stored_count,
    input  ready
  );
  modport sink (
    input  valid, shifted_start_us, shifted_end_us, display_action, shown_payload_id,
           shown_is_bitmap, stored_count,
    output ready
  );
endinterface

/* rtl/tcws_ram.sv */
// ----------------------------------------------------------------------------
// tcws_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/timed_cue_window_scheduler.sv */
// ----------------------------------------------------------------------------
// timed_cue_window_scheduler
// Cue store kept as a ring in one RAM; ticks scan and compact it in place.
// ----------------------------------------------------------------------------
// One request is taken at a time. A push, a flush, an ignored tick or an
// unused request type goes straight to the output state; a valid tick first
// scans every stored cue. The single RAM read port streams one entry a cycle,
// and kept entries are written back behind the read pointer in the same pass,
// so the window search and the compaction share one sweep. The next request
// is taken as soon as the result sits in the output register.
// ----------------------------------------------------------------------------
module timed_cue_window_scheduler #(
  parameter int CUE_CAPACITY = 1024,
  parameter int TIME_BITS    = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tcws_pkg::DELAY_W-1:0]  cfg_wdata,
  tcws_req_if.sink                      req,
  tcws_res_if.source                    res
);
  import tcws_pkg::*;

  localparam int AW  = (CUE_CAPACITY > 1) ? $clog2(CUE_CAPACITY) : 1;
  localparam int CW  = $clog2(CUE_CAPACITY + 1);
  localparam int SW  = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;
  localparam int MW  = 2 * TIME_BITS + ID_W + 1;

  localparam logic [AW-1:0] LAST  = AW'(CUE_CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C = CW'(CUE_CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam logic signed [SW-1:0] T_MAX = {{(SW-TIME_BITS+1){1'b0}}, {(TIME_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] T_MIN = ~T_MAX;

  function automatic logic [TIME_BITS-1:0] add_sat(logic signed [TIME_BITS-1:0] a,
                                                  logic signed [DELAY_W-1:0] d);
    logic signed [SW-1:0] sum;
    sum = SW'(a) + SW'(d);
    if (sum > T_MAX) begin
      return T_MAX[TIME_BITS-1:0];
    end else if (sum < T_MIN) begin
      return T_MIN[TIME_BITS-1:0];
    end
    return sum[TIME_BITS-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_wrap(logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  logic [1:0]                  state;
  logic [DELAY_W-1:0]          delay;
  logic [AW-1:0]               head;
  logic [CW-1:0]               cnt;
  logic                        active;
  logic signed [TIME_BITS-1:0] active_start;
  logic                        active_kind;

  logic signed [TIME_BITS-1:0] now;
  logic [AW-1:0]               rd_ptr;
  logic [CW-1:0]               rd_left;
  logic                        rd_vld;
  logic [AW-1:0]               wr_ptr;
  logic [CW-1:0]               wr_cnt;
  logic                        hit_found;
  logic signed [TIME_BITS-1:0] hit_start;
  logic                        hit_kind;
  logic [ID_W-1:0]             hit_id;

  logic [TIME_BITS-1:0]        p_ss;
  logic [TIME_BITS-1:0]        p_se;
  logic [ACT_W-1:0]            p_act;
  logic [ID_W-1:0]             p_id;
  logic                        p_kind;
  logic                        out_vld;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [MW-1:0]               ram_wdata;
  logic [MW-1:0]               ram_rdata;

  logic [TIME_BITS-1:0]        sh_start;
  logic [TIME_BITS-1:0]        sh_end;
  logic [AW:0]                 tail_sum;
  logic [AW-1:0]               tail;
  logic signed [TIME_BITS-1:0] e_start;
  logic signed [TIME_BITS-1:0] e_end;
  logic [ID_W-1:0]             e_id;
  logic                        e_kind;
  logic                        e_keep;
  logic                        e_match;
  logic                        accept;
  logic                        out_load;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_vld || res.ready);

  assign sh_start = add_sat(req.cue_start_us, delay);
  assign sh_end   = add_sat(req.cue_end_us, delay);
  assign tail_sum = {1'b0, head} + (AW+1)'(cnt);
  assign tail     = (tail_sum >= (AW+1)'(CUE_CAPACITY)) ?
                    AW'(tail_sum - (AW+1)'(CUE_CAPACITY)) : tail_sum[AW-1:0];

  assign e_start = ram_rdata[TIME_BITS-1:0];
  assign e_end   = ram_rdata[2*TIME_BITS-1:TIME_BITS];
  assign e_id    = ram_rdata[2*TIME_BITS+ID_W-1:2*TIME_BITS];
  assign e_kind  = ram_rdata[MW-1];
  assign e_keep  = now < e_end;
  assign e_match = (e_start <= now) && e_keep;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_ptr;
    ram_wdata = ram_rdata;
    if (state == S_IDLE && accept && req.req_type == REQ_PUSH && req.cue_renderable) begin
      ram_we    = 1'b1;
      ram_waddr = tail;
      ram_wdata = {req.cue_is_bitmap, req.cue_payload_id, sh_end, sh_start};
    end else if (state == S_SCAN && rd_vld && e_keep) begin
      ram_we    = 1'b1;
    end
  end

  tcws_ram #(
    .WIDTH (MW),
    .DEPTH (CUE_CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      delay       <= '0;
      head        <= '0;
      cnt         <= '0;
      active      <= 1'b0;
      active_start <= '0;
      active_kind <= 1'b0;
      out_vld     <= 1'b0;
      rd_vld      <= 1'b0;
      rd_left     <= '0;
    end else begin
      if (cfg_we) begin
        delay <= cfg_wdata;
      end
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (res.ready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            p_ss   <= (req.req_type == REQ_PUSH) ? sh_start : '0;
            p_se   <= (req.req_type == REQ_PUSH) ? sh_end : '0;
            p_act  <= (req.req_type == REQ_FLUSH && active) ? ACT_CLEAR : ACT_NONE;
            p_id   <= '0;
            p_kind <= 1'b0;
            state  <= (req.req_type == REQ_TICK && req.clock_valid) ? S_SCAN : S_OUT;
            case (req.req_type)
              REQ_PUSH: begin
                if (req.cue_renderable) begin
                  if (cnt == CAP_C) begin
                    head <= inc_wrap(head);
                  end else begin
                    cnt <= cnt + CW'(1);
                  end
                end
              end
              REQ_TICK: begin
                if (req.clock_valid) begin
                  now       <= req.now_us;
                  rd_ptr    <= head;
                  wr_ptr    <= head;
                  rd_left   <= cnt;
                  rd_vld    <= 1'b0;
                  wr_cnt    <= '0;
                  hit_found <= 1'b0;
                end
              end
              REQ_FLUSH: begin
                cnt    <= '0;
                active <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_left != '0) begin
            rd_ptr  <= inc_wrap(rd_ptr);
            rd_left <= rd_left - CW'(1);
            rd_vld  <= 1'b1;
          end else begin
            rd_vld  <= 1'b0;
          end
          if (rd_vld) begin
            if (e_keep) begin
              wr_ptr <= inc_wrap(wr_ptr);
              wr_cnt <= wr_cnt + CW'(1);
            end
            if (e_match) begin
              hit_found <= 1'b1;
              hit_start <= e_start;
              hit_kind  <= e_kind;
              hit_id    <= e_id;
            end
          end else if (rd_left == '0) begin
            cnt   <= wr_cnt;
            state <= S_OUT;
            if (!hit_found) begin
              active <= 1'b0;
              if (active) begin
                p_act <= ACT_CLEAR;
              end
            end else if (!(active && hit_start == active_start && hit_kind == active_kind)) begin
              active       <= 1'b1;
              active_start <= hit_start;
              active_kind  <= hit_kind;
              p_act        <= ACT_SHOW;
              p_id         <= hit_id;
              p_kind       <= hit_kind;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.shifted_start_us <= p_ss;
      res.shifted_end_us   <= p_se;
      res.display_action   <= p_act;
      res.shown_payload_id <= p_id;
      res.shown_is_bitmap  <= p_kind;
      res.stored_count     <= cnt;
    end
  end

  assign res.valid = out_vld;

endmodule
